// ----- rtl/lsplit_pkg.sv -----
// ----------------------------------------------------------------------------
// lsplit_pkg
// shared constants, codes and types of the line splitter
// ----------------------------------------------------------------------------
package lsplit_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int STORE_DEPTH   = 64;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
  localparam int BYTE_W        = 8;

  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    KIND_LINE = 2'd0,
    KIND_OVF  = 2'd1,
    KIND_TAIL = 2'd2
  } piece_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR_CHK,
    ST_RD,
    ST_OUT,
    ST_BSL,
    ST_CP0,
    ST_CP1,
    ST_CP2,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic              load;
    logic [BYTE_W-1:0] line_byte;
    logic              last_of_piece;
    piece_kind_t       piece_kind;
    logic              empty_line;
  } emit_t;

endpackage

// ----- rtl/lsplit_if.sv -----
// ----------------------------------------------------------------------------
// lsplit_if
// valid/ready channels for input bytes and emitted line items
// ----------------------------------------------------------------------------
interface lsplit_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [lsplit_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface lsplit_out_if;
  logic                           valid;
  logic                           ready;
  logic [lsplit_pkg::BYTE_W-1:0]  line_byte;
  logic                           last_of_piece;
  logic [1:0]                     piece_kind;
  logic                           empty_line;

  modport source (output valid, output line_byte, output last_of_piece,
                  output piece_kind, output empty_line, input ready);
  modport sink   (input valid, input line_byte, input last_of_piece,
                  input piece_kind, input empty_line, output ready);
endinterface

// ----- rtl/lsplit_ram.sv -----
// ----------------------------------------------------------------------------
// lsplit_ram
// single-port synchronous ram, read-first, registered read data
// ----------------------------------------------------------------------------
module lsplit_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/lsplit_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsplit_ctrl
// sequencer: stores bytes, checks trailing carriage return, reads lines out
// ----------------------------------------------------------------------------
module lsplit_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [lsplit_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                          out_free,
  output lsplit_pkg::emit_t             emit,
  output lsplit_pkg::ram_req_t          ram_req,
  input  logic [lsplit_pkg::BYTE_W-1:0] ram_rdata
);

  localparam int CNT_W  = lsplit_pkg::CNT_W;
  localparam int ADDR_W = lsplit_pkg::ADDR_W;

  lsplit_pkg::state_t            state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              len_r, len_nxt;
  logic [ADDR_W-1:0]             idx_r, idx_nxt;
  lsplit_pkg::piece_kind_t       kind_r, kind_nxt;
  logic [lsplit_pkg::BYTE_W-1:0] byte_r, byte_nxt;

  logic             accept;
  logic             is_nl;
  logic             at_end;
  logic [CNT_W-1:0] cr_len;

  assign accept = in_valid && in_ready;
  assign is_nl  = (in_data_byte == lsplit_pkg::CH_NEWLINE);
  assign at_end = ((CNT_W'(idx_r) + CNT_W'(1)) == len_r);
  assign cr_len = (ram_rdata == lsplit_pkg::CH_CR) ? (cnt_r - CNT_W'(1)) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsplit_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    unique case (state_r)
      lsplit_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (in_mode == lsplit_pkg::MODE_FLUSH) begin
            if (cnt_r != '0) begin
              len_nxt   = cnt_r;
              idx_nxt   = '0;
              kind_nxt  = lsplit_pkg::KIND_TAIL;
              state_nxt = lsplit_pkg::ST_RD;
            end
          end else if (is_nl) begin
            state_nxt = (cnt_r == '0) ? lsplit_pkg::ST_EMPTY : lsplit_pkg::ST_CR_CHK;
          end else if (cnt_r == CNT_W'(lsplit_pkg::LINE_CAPACITY - 1)) begin
            byte_nxt  = in_data_byte;
            len_nxt   = CNT_W'(lsplit_pkg::LINE_CAPACITY - 2);
            idx_nxt   = '0;
            kind_nxt  = lsplit_pkg::KIND_OVF;
            state_nxt = lsplit_pkg::ST_RD;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      lsplit_pkg::ST_CR_CHK: begin
        len_nxt   = cr_len;
        idx_nxt   = '0;
        kind_nxt  = lsplit_pkg::KIND_LINE;
        state_nxt = (cr_len == '0) ? lsplit_pkg::ST_EMPTY : lsplit_pkg::ST_RD;
      end
      lsplit_pkg::ST_RD: begin
        state_nxt = lsplit_pkg::ST_OUT;
      end
      lsplit_pkg::ST_OUT: begin
        if (out_free) begin
          idx_nxt = idx_r + ADDR_W'(1);
          if (at_end) begin
            if (kind_r == lsplit_pkg::KIND_OVF) begin
              state_nxt = lsplit_pkg::ST_BSL;
            end else begin
              cnt_nxt   = '0;
              state_nxt = lsplit_pkg::ST_IDLE;
            end
          end else begin
            state_nxt = lsplit_pkg::ST_RD;
          end
        end
      end
      lsplit_pkg::ST_BSL: begin
        if (out_free) begin
          state_nxt = lsplit_pkg::ST_CP0;
        end
      end
      lsplit_pkg::ST_CP0: begin
        state_nxt = lsplit_pkg::ST_CP1;
      end
      lsplit_pkg::ST_CP1: begin
        state_nxt = lsplit_pkg::ST_CP2;
      end
      lsplit_pkg::ST_CP2: begin
        cnt_nxt   = CNT_W'(2);
        state_nxt = lsplit_pkg::ST_IDLE;
      end
      lsplit_pkg::ST_EMPTY: begin
        if (out_free) begin
          cnt_nxt   = '0;
          state_nxt = lsplit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lsplit_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready           = 1'b0;
    ram_req.we         = 1'b0;
    ram_req.addr       = idx_r;
    ram_req.wdata      = in_data_byte;
    emit.load          = 1'b0;
    emit.line_byte     = ram_rdata;
    emit.last_of_piece = 1'b0;
    emit.piece_kind    = kind_r;
    emit.empty_line    = 1'b0;
    unique case (state_r)
      lsplit_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && in_mode == lsplit_pkg::MODE_DATA && is_nl) begin
          ram_req.addr = cnt_r[ADDR_W-1:0] - ADDR_W'(1);
        end else begin
          ram_req.addr = cnt_r[ADDR_W-1:0];
        end
        ram_req.we = accept && (in_mode == lsplit_pkg::MODE_DATA) && !is_nl;
      end
      lsplit_pkg::ST_OUT: begin
        emit.load          = out_free;
        emit.last_of_piece = at_end && (kind_r != lsplit_pkg::KIND_OVF);
      end
      lsplit_pkg::ST_BSL: begin
        emit.load          = out_free;
        emit.line_byte     = lsplit_pkg::CH_BACKSLASH;
        emit.last_of_piece = 1'b1;
        emit.piece_kind    = lsplit_pkg::KIND_OVF;
      end
      lsplit_pkg::ST_CP0: begin
        ram_req.addr = ADDR_W'(lsplit_pkg::LINE_CAPACITY - 2);
      end
      lsplit_pkg::ST_CP1: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = ADDR_W'(0);
        ram_req.wdata = ram_rdata;
      end
      lsplit_pkg::ST_CP2: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = ADDR_W'(1);
        ram_req.wdata = byte_r;
      end
      lsplit_pkg::ST_EMPTY: begin
        emit.load          = out_free;
        emit.line_byte     = '0;
        emit.last_of_piece = 1'b1;
        emit.piece_kind    = lsplit_pkg::KIND_LINE;
        emit.empty_line    = 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(lsplit_pkg::LINE_CAPACITY))
    else $error("stored count reached capacity");

  a_store_byte: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == lsplit_pkg::MODE_DATA && !is_nl &&
    cnt_r != CNT_W'(lsplit_pkg::LINE_CAPACITY - 1)
    |=> state_r == lsplit_pkg::ST_IDLE && cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("plain byte did not advance the count");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == lsplit_pkg::MODE_FLUSH && cnt_r == '0
    |=> state_r == lsplit_pkg::ST_IDLE)
    else $error("flush of empty store started a readout");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load && emit.last_of_piece && emit.piece_kind == lsplit_pkg::KIND_OVF
    |-> emit.line_byte == lsplit_pkg::CH_BACKSLASH)
    else $error("overflow piece not closed by backslash");
`endif

endmodule

// ----- rtl/line_splitter_with_overflow.sv -----
// ----------------------------------------------------------------------------
// line_splitter_with_overflow
// splits a byte stream into lines held in a 64-byte line store
// ----------------------------------------------------------------------------
// in_if carries one transaction per byte (mode 0) or an end-of-stream flush
// (mode 1); out_if carries one transaction per emitted line byte, with
// last_of_piece on the final one, piece_kind and empty_line.
// a plain byte is written straight into the store, so back-to-back bytes are
// taken every cycle until the store fills. a newline first reads the byte
// before it for the carriage return check. each emitted byte is one store
// read, then one load of the output register. an overflow piece adds the
// backslash, then states CP0, CP1 and CP2 move the last two bytes to the
// front. all store traffic goes through one single-port ram. no new byte is
// taken while a piece is being read out. a newline reaches out_if through
// the carriage return check and a store read, a flush or the filling byte
// through a store read, a lone carriage return through the check alone and
// a newline on an empty store directly, each via the output register.
// reset clears the count and the sequencer; store contents are not cleared.
// a stalled receiver holds the output register and freezes the readout.
// ----------------------------------------------------------------------------
module line_splitter_with_overflow (
  input  logic                clk,
  input  logic                rst_n,
  lsplit_in_if.sink           in_if,
  lsplit_out_if.source        out_if
);

  lsplit_pkg::emit_t             emit;
  lsplit_pkg::ram_req_t          ram_req;
  logic [lsplit_pkg::BYTE_W-1:0] ram_rdata;
  logic                          out_free;

  logic                          out_valid_r;
  logic [lsplit_pkg::BYTE_W-1:0] out_byte_r;
  logic                          out_last_r;
  logic [1:0]                    out_kind_r;
  logic                          out_empty_r;

  assign out_free = !out_valid_r || out_if.ready;

  lsplit_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_mode      (in_if.mode),
    .in_data_byte (in_if.data_byte),
    .out_free     (out_free),
    .emit         (emit),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

  lsplit_ram #(
    .DEPTH (lsplit_pkg::STORE_DEPTH),
    .WIDTH (lsplit_pkg::BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit.load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.load) begin
      out_byte_r  <= emit.line_byte;
      out_last_r  <= emit.last_of_piece;
      out_kind_r  <= emit.piece_kind;
      out_empty_r <= emit.empty_line;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.line_byte     = out_byte_r;
  assign out_if.last_of_piece = out_last_r;
  assign out_if.piece_kind    = out_kind_r;
  assign out_if.empty_line    = out_empty_r;

endmodule
